// ===== sv/tcp_connection_state_machine_defines.svh =====
// Assertion macros shared by the connection state machine RTL.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef TCP_CONNECTION_STATE_MACHINE_DEFINES_SVH
`define TCP_CONNECTION_STATE_MACHINE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcs check failed");
// Next-cycle implication.
`define TCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcs check failed");
`else
`define TCS_ASSERT_IMP(lbl, ante, cons)
`define TCS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/tcs_pkg.sv =====
// Types and constants of the TCP connection state machine.
// No dependencies; used by tcs_front, tcs_queue, tcs_back, the top level and the testbench.
`default_nettype none

package tcs_pkg;

  typedef enum logic [2:0] {
    ST_CLOSED      = 3'd0,
    ST_LISTEN      = 3'd1,
    ST_SYN_RCVD    = 3'd2,
    ST_SYN_SENT    = 3'd3,
    ST_ESTABLISHED = 3'd4,
    ST_FIN_WAIT1   = 3'd5,
    ST_FIN_WAIT2   = 3'd6,
    ST_CLOSE_WAIT  = 3'd7
  } conn_state_t;

  // Operation codes on the input channel.
  localparam logic [1:0] OP_SEGMENT = 2'd0;
  localparam logic [1:0] OP_LISTEN  = 2'd1;
  localparam logic [1:0] OP_CONNECT = 2'd2;

  // Flag bit positions.
  localparam int unsigned FLAG_FIN = 0;
  localparam int unsigned FLAG_SYN = 1;
  localparam int unsigned FLAG_RST = 2;
  localparam int unsigned FLAG_PSH = 3;
  localparam int unsigned FLAG_ACK = 4;

  localparam logic [7:0] REPLY_NONE   = 8'h00;
  localparam logic [7:0] REPLY_ACK    = 8'h10;
  localparam logic [7:0] REPLY_SYNACK = 8'h12;

  localparam logic [1:0] NOTICE_NONE  = 2'd0;
  localparam logic [1:0] NOTICE_WRITE = 2'd1;
  localparam logic [1:0] NOTICE_CLOSE = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    EV_SEGMENT = 2'd0,
    EV_PASSIVE = 2'd1,
    EV_ACTIVE  = 2'd2,
    EV_NONE    = 2'd3
  } event_kind_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    event_kind_t kind;
    logic        fin;
    logic        syn;
    logic        rst;
    logic        psh;
    logic        ack;
    logic        len_nz;
    logic [31:0] seq;
    logic [31:0] seq_plus1;
    logic [31:0] seq_plus_len;
    logic [31:0] seg_ack;
    logic [31:0] iss;
  } seg_item_t;

  typedef struct packed {
    logic        send_segment;
    logic [7:0]  reply_flags;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;
    logic [1:0]  socket_notice;
    logic        deliver_payload;
    logic        release_connection;
    conn_state_t next_state;
    logic [31:0] received_mark;
  } seg_result_t;

endpackage

`default_nettype wire

// ===== sv/tcs_if.sv =====
// Valid/ready channel interfaces for segment items and result items.
// Standalone; no package needed.
`default_nettype none

interface tcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  tcp_flags;
  logic [31:0] seg_seq;
  logic [31:0] seg_ack;
  logic [15:0] payload_length;
  logic [31:0] initial_seq;

  modport source (output valid, operation, tcp_flags, seg_seq, seg_ack,
                  payload_length, initial_seq, input ready);
  modport sink   (input valid, operation, tcp_flags, seg_seq, seg_ack,
                  payload_length, initial_seq, output ready);
endinterface

interface tcs_out_if;
  logic        valid;
  logic        ready;
  logic        send_segment;
  logic [7:0]  reply_flags;
  logic [31:0] reply_seq;
  logic [31:0] reply_ack;
  logic [1:0]  socket_notice;
  logic        deliver_payload;
  logic        release_connection;
  logic [2:0]  next_state;
  logic [31:0] received_mark;

  modport source (output valid, send_segment, reply_flags, reply_seq, reply_ack,
                  socket_notice, deliver_payload, release_connection, next_state,
                  received_mark, input ready);
  modport sink   (input valid, send_segment, reply_flags, reply_seq, reply_ack,
                  socket_notice, deliver_payload, release_connection, next_state,
                  received_mark, output ready);
endinterface

`default_nettype wire

// ===== sv/tcs_front.sv =====
// Front end: accepts input items, decodes flags and precomputes sequence sums.
// Depends on tcs_pkg and tcs_in_if.
`default_nettype none

module tcs_front
  import tcs_pkg::*;
(
  tcs_in_if.sink    in_seg,
  input  logic      q_full,
  output logic      push,
  output seg_item_t push_item
);

  assign in_seg.ready = !q_full;
  assign push         = in_seg.valid && !q_full;

  always_comb begin
    case (in_seg.operation)
      OP_SEGMENT: push_item.kind = EV_SEGMENT;
      OP_LISTEN:  push_item.kind = EV_PASSIVE;
      OP_CONNECT: push_item.kind = EV_ACTIVE;
      default:    push_item.kind = EV_NONE;
    endcase
    push_item.fin          = in_seg.tcp_flags[FLAG_FIN];
    push_item.syn          = in_seg.tcp_flags[FLAG_SYN];
    push_item.rst          = in_seg.tcp_flags[FLAG_RST];
    push_item.psh          = in_seg.tcp_flags[FLAG_PSH];
    push_item.ack          = in_seg.tcp_flags[FLAG_ACK];
    push_item.len_nz       = |in_seg.payload_length;
    push_item.seq          = in_seg.seg_seq;
    push_item.seq_plus1    = in_seg.seg_seq + 32'd1;
    push_item.seq_plus_len = in_seg.seg_seq + {16'd0, in_seg.payload_length};
    push_item.seg_ack      = in_seg.seg_ack;
    push_item.iss          = in_seg.initial_seq;
  end

endmodule

`default_nettype wire

// ===== sv/tcs_queue.sv =====
// Two-entry queue of classified items between front end and back end.
// Depends on tcs_pkg and the assertion macros.
`default_nettype none
`include "tcp_connection_state_machine_defines.svh"

module tcs_queue
  import tcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  seg_item_t push_item,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output seg_item_t head_item
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  seg_item_t       entry_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r,  count_nxt;

  assign full       = (count_r == CntW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `TCS_ASSERT_IMP(a_q_no_overflow, full, !push)
  `TCS_ASSERT_IMP(a_q_no_underflow, !head_valid, !pop)

endmodule

`default_nettype wire

// ===== sv/tcs_back.sv =====
// Back end: holds connection state, carries out each item, drives the result register.
// Depends on tcs_pkg, tcs_out_if and the assertion macros.
`default_nettype none
`include "tcp_connection_state_machine_defines.svh"

module tcs_back
  import tcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  seg_item_t  head_item,
  output logic       pop,
  tcs_out_if.source  out_res
);

  conn_state_t state_r, state_nxt;
  logic [31:0] last_rcv_r, last_rcv_nxt;
  logic        out_valid_r;
  seg_result_t res_r, res_nxt;

  assign pop = head_valid && (!out_valid_r || out_res.ready);

  always_comb begin
    state_nxt    = state_r;
    last_rcv_nxt = last_rcv_r;
    res_nxt      = '0;
    case (head_item.kind)
      EV_PASSIVE: begin
        if (state_r == ST_CLOSED) state_nxt = ST_LISTEN;
      end
      EV_ACTIVE: begin
        if (state_r == ST_CLOSED) state_nxt = ST_SYN_SENT;
      end
      EV_SEGMENT: begin
        case (state_r)
          ST_LISTEN: begin
            if (head_item.syn) begin
              res_nxt.send_segment = 1'b1;
              res_nxt.reply_flags  = REPLY_SYNACK;
              res_nxt.reply_seq    = head_item.iss;
              res_nxt.reply_ack    = head_item.seq_plus1;
              state_nxt            = ST_SYN_RCVD;
              last_rcv_nxt         = head_item.seq_plus1;
            end
          end
          ST_SYN_RCVD: begin
            if (head_item.ack && !head_item.syn) begin
              state_nxt               = ST_ESTABLISHED;
              last_rcv_nxt            = head_item.seq_plus1;
              res_nxt.deliver_payload = head_item.len_nz;
            end
          end
          ST_SYN_SENT: begin
            if (head_item.syn && head_item.ack) begin
              res_nxt.send_segment  = 1'b1;
              res_nxt.reply_flags   = REPLY_ACK;
              res_nxt.reply_seq     = head_item.seg_ack;
              res_nxt.reply_ack     = head_item.seq_plus1;
              res_nxt.socket_notice = NOTICE_WRITE;
              state_nxt             = ST_ESTABLISHED;
              last_rcv_nxt          = head_item.seq_plus1;
            end
          end
          ST_ESTABLISHED: begin
            if (!head_item.fin && !head_item.syn && !head_item.rst && head_item.psh) begin
              // data push: ack everything up to the end of the payload
              res_nxt.send_segment    = 1'b1;
              res_nxt.reply_flags     = REPLY_ACK;
              res_nxt.reply_seq       = head_item.seg_ack;
              res_nxt.reply_ack       = head_item.seq_plus_len;
              res_nxt.socket_notice   = NOTICE_WRITE;
              res_nxt.deliver_payload = 1'b1;
              last_rcv_nxt            = head_item.seq_plus_len;
            end else if (head_item.ack && !head_item.fin) begin
              last_rcv_nxt = head_item.seq;
            end else if (head_item.fin) begin
              res_nxt.send_segment = 1'b1;
              res_nxt.reply_flags  = REPLY_ACK;
              res_nxt.reply_seq    = head_item.seg_ack;
              res_nxt.reply_ack    = head_item.seq_plus1;
              state_nxt            = ST_CLOSE_WAIT;
              last_rcv_nxt         = head_item.seq_plus1;
            end
          end
          ST_FIN_WAIT1: begin
            if (head_item.fin && head_item.ack) begin
              res_nxt.send_segment = 1'b1;
              res_nxt.reply_flags  = REPLY_ACK;
              res_nxt.reply_seq    = head_item.seg_ack;
              res_nxt.reply_ack    = head_item.seq_plus1;
              state_nxt            = ST_FIN_WAIT2;
              last_rcv_nxt         = head_item.seq_plus1;
            end
          end
          ST_FIN_WAIT2: begin
            if (head_item.ack) begin
              res_nxt.send_segment       = 1'b1;
              res_nxt.reply_flags        = REPLY_ACK;
              res_nxt.reply_seq          = head_item.seg_ack;
              res_nxt.reply_ack          = head_item.seq_plus1;
              res_nxt.socket_notice      = NOTICE_CLOSE;
              res_nxt.release_connection = 1'b1;
              state_nxt                  = ST_CLOSED;
              last_rcv_nxt               = head_item.seq_plus1;
            end
          end
          ST_CLOSE_WAIT: begin
            if (head_item.ack) begin
              res_nxt.socket_notice      = NOTICE_CLOSE;
              res_nxt.release_connection = 1'b1;
              state_nxt                  = ST_CLOSED;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    res_nxt.next_state    = state_nxt;
    res_nxt.received_mark = last_rcv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLOSED;
      last_rcv_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        state_r    <= state_nxt;
        last_rcv_r <= last_rcv_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid              = out_valid_r;
  assign out_res.send_segment       = res_r.send_segment;
  assign out_res.reply_flags        = res_r.reply_flags;
  assign out_res.reply_seq          = res_r.reply_seq;
  assign out_res.reply_ack          = res_r.reply_ack;
  assign out_res.socket_notice      = res_r.socket_notice;
  assign out_res.deliver_payload    = res_r.deliver_payload;
  assign out_res.release_connection = res_r.release_connection;
  assign out_res.next_state         = res_r.next_state;
  assign out_res.received_mark      = res_r.received_mark;

  // The held result always reflects the live connection state.
  `TCS_ASSERT_IMP(a_held_state, out_valid_r, res_r.next_state == state_r && res_r.received_mark == last_rcv_r)
  `TCS_ASSERT_IMP(a_reply_flags, out_valid_r && res_r.send_segment, res_r.reply_flags == REPLY_ACK || res_r.reply_flags == REPLY_SYNACK)
  `TCS_ASSERT_IMP(a_release_closed, out_valid_r && res_r.release_connection, res_r.next_state == ST_CLOSED && res_r.socket_notice == NOTICE_CLOSE)
  `TCS_ASSERT_NXT(a_pop_loads, pop, out_valid_r)

endmodule

`default_nettype wire

// ===== sv/tcp_connection_state_machine.sv =====
// Top level of the single-connection TCP state machine.
// Depends on tcs_pkg, tcs_if, tcs_front, tcs_queue and tcs_back.
//
//   channel   port      direction  carries
//   -------   -------   ---------  -------------------------------------------
//   input     in_seg    sink       operation, flags, seq/ack, length, our ISS
//   result    out_res   source     reply fields, notices, next state, rcv mark
//
// One item per cycle sustained while the receiver takes every result; an item
// accepted into an empty queue is first written into the queue, then loaded into
// the result register with the state update, and out_res then offers it.
// The back-end state update is the only loop: one item per cycle unless stalled.
// Reset (rst_n low, synchronous) returns to CLOSED with a zero receive mark and
// an empty queue. A stalled result holds while up to two more items are queued.
`default_nettype none

module tcp_connection_state_machine
  import tcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tcs_in_if.sink    in_seg,
  tcs_out_if.source out_res
);

  logic      push;
  seg_item_t push_item;
  logic      q_full;
  logic      pop;
  logic      head_valid;
  seg_item_t head_item;

  // Front: flag decode and the two 32-bit sums, no state.
  tcs_front u_front (
    .in_seg    (in_seg),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue: front and back stall independently.
  tcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Back: connection state, receive mark and result register.
  tcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_res    (out_res)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the single-connection TCP state machine.
// Needs tcs_pkg, tcs_if and the tcp_connection_state_machine RTL; nothing else.
// Predicts each result in step with the input stream and checks every field.
`timescale 1ns / 100ps

module testbench;
  import tcs_pkg::*;

  // Flag masks built from the package bit positions.
  localparam logic [7:0] M_FIN   = 8'h01 << FLAG_FIN;
  localparam logic [7:0] M_SYN   = 8'h01 << FLAG_SYN;
  localparam logic [7:0] M_RST   = 8'h01 << FLAG_RST;
  localparam logic [7:0] M_PSH   = 8'h01 << FLAG_PSH;
  localparam logic [7:0] M_ACK   = 8'h01 << FLAG_ACK;
  localparam logic [7:0] M_SPARE = 8'hE0;  // bits with no meaning to the block

  localparam logic [1:0] OP_UNUSED = 2'd3;  // undefined operation code

  // Receiver stall patterns.
  localparam logic [1:0] RX_OPEN  = 2'd0;
  localparam logic [1:0] RX_LIGHT = 2'd1;
  localparam logic [1:0] RX_HEAVY = 2'd2;
  localparam logic [1:0] RX_COMB  = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no item moving
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tcs_in_if  in_seg ();
  tcs_out_if out_res ();

  tcp_connection_state_machine u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_seg  (in_seg),
    .out_res (out_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the connection as the block should see it after every item
  // handed to the sender so far.
  conn_state_t conn_state = ST_CLOSED;
  logic [31:0] rcv_mark   = '0;

  seg_result_t predicted_results[$];

  int unsigned mismatches   = 0;
  int unsigned burst_left   = 0;

  // One segment or open event applied to the shadow connection.
  function automatic seg_result_t advance_connection(
      input logic [1:0]  op,
      input logic [7:0]  flags,
      input logic [31:0] seq,
      input logic [31:0] ack,
      input logic [15:0] len,
      input logic [31:0] iss);
    seg_result_t r;
    logic        has_fin, has_syn, has_rst, has_psh, has_ack;
    logic [31:0] seq_next, data_end;
    r        = '0;
    has_fin  = flags[FLAG_FIN];
    has_syn  = flags[FLAG_SYN];
    has_rst  = flags[FLAG_RST];
    has_psh  = flags[FLAG_PSH];
    has_ack  = flags[FLAG_ACK];
    seq_next = seq + 32'd1;
    data_end = seq + 32'(len);
    if (op == OP_LISTEN) begin
      if (conn_state == ST_CLOSED) conn_state = ST_LISTEN;
    end else if (op == OP_CONNECT) begin
      if (conn_state == ST_CLOSED) conn_state = ST_SYN_SENT;
    end else if (op == OP_SEGMENT) begin
      case (conn_state)
        ST_LISTEN: begin
          if (has_syn) begin
            r.send_segment = 1'b1;
            r.reply_flags  = REPLY_SYNACK;
            r.reply_seq    = iss;
            r.reply_ack    = seq_next;
            conn_state     = ST_SYN_RCVD;
            rcv_mark       = seq_next;
          end
        end
        ST_SYN_RCVD: begin
          if (has_ack && !has_syn) begin
            conn_state        = ST_ESTABLISHED;
            rcv_mark          = seq_next;
            r.deliver_payload = (len != 16'd0);
          end
        end
        ST_SYN_SENT: begin
          if (has_syn && has_ack) begin
            r.send_segment  = 1'b1;
            r.reply_flags   = REPLY_ACK;
            r.reply_seq     = ack;
            r.reply_ack     = seq_next;
            r.socket_notice = NOTICE_WRITE;
            conn_state      = ST_ESTABLISHED;
            rcv_mark        = seq_next;
          end
        end
        ST_ESTABLISHED: begin
          // data push wins over everything but FIN, SYN and RST
          if (has_psh && !has_fin && !has_syn && !has_rst) begin
            r.send_segment    = 1'b1;
            r.reply_flags     = REPLY_ACK;
            r.reply_seq       = ack;
            r.reply_ack       = data_end;
            r.socket_notice   = NOTICE_WRITE;
            r.deliver_payload = 1'b1;
            rcv_mark          = data_end;
          end else if (has_ack && !has_fin) begin
            rcv_mark = seq;
          end else if (has_fin) begin
            r.send_segment = 1'b1;
            r.reply_flags  = REPLY_ACK;
            r.reply_seq    = ack;
            r.reply_ack    = seq_next;
            conn_state     = ST_CLOSE_WAIT;
            rcv_mark       = seq_next;
          end
        end
        ST_FIN_WAIT1: begin
          if (has_fin && has_ack) begin
            r.send_segment = 1'b1;
            r.reply_flags  = REPLY_ACK;
            r.reply_seq    = ack;
            r.reply_ack    = seq_next;
            conn_state     = ST_FIN_WAIT2;
            rcv_mark       = seq_next;
          end
        end
        ST_FIN_WAIT2: begin
          if (has_ack) begin
            r.send_segment       = 1'b1;
            r.reply_flags        = REPLY_ACK;
            r.reply_seq          = ack;
            r.reply_ack          = seq_next;
            r.socket_notice      = NOTICE_CLOSE;
            r.release_connection = 1'b1;
            conn_state           = ST_CLOSED;
            rcv_mark             = seq_next;
          end
        end
        ST_CLOSE_WAIT: begin
          if (has_ack) begin
            r.socket_notice      = NOTICE_CLOSE;
            r.release_connection = 1'b1;
            conn_state           = ST_CLOSED;
          end
        end
        default: begin
        end
      endcase
    end
    r.next_state    = conn_state;
    r.received_mark = rcv_mark;
    return r;
  endfunction

  // Drive one item and hold it until the block takes it. The sender runs in
  // bursts; a burst may be followed by a gap with valid low.
  task automatic send_item(
      input logic [1:0]  op,
      input logic [7:0]  flags,
      input logic [31:0] seq,
      input logic [31:0] ack,
      input logic [15:0] len,
      input logic [31:0] iss);
    seg_result_t predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_seg.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    predicted         = advance_connection(op, flags, seq, ack, len, iss);
    predicted_results = {predicted_results, predicted};
    in_seg.valid          <= 1'b1;
    in_seg.operation      <= op;
    in_seg.tcp_flags      <= flags;
    in_seg.seg_seq        <= seq;
    in_seg.seg_ack        <= ack;
    in_seg.payload_length <= len;
    in_seg.initial_seq    <= iss;
    do @(posedge clk); while (!in_seg.ready);
  endtask

  // Mostly the segment the current state is waiting for, with random content;
  // about one in five is raw noise with any operation code.
  task automatic send_random_item();
    logic [1:0]  op;
    logic [7:0]  fl;
    logic [31:0] sq, ak, iss;
    logic [15:0] len;
    int unsigned pick;
    op  = OP_SEGMENT;
    fl  = 8'($urandom);
    sq  = $urandom;
    ak  = $urandom;
    iss = $urandom;
    len = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    // sequence numbers just short of the wrap point
    if ($urandom_range(0, 15) == 0) sq = ~32'($urandom_range(0, 16'hFFFF));
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      op = 2'($urandom_range(0, 3));
    end else begin
      case (conn_state)
        ST_CLOSED: begin
          op = ($urandom_range(0, 1) != 0) ? OP_LISTEN : OP_CONNECT;
        end
        ST_LISTEN:   fl = fl | M_SYN;
        ST_SYN_RCVD: fl = (fl & ~M_SYN) | M_ACK;
        ST_SYN_SENT: fl = fl | M_SYN | M_ACK;
        ST_ESTABLISHED: begin
          // keep sessions open for a while: data mostly, FIN rarely
          pick = $urandom_range(0, 15);
          if (pick < 9) fl = (fl & ~(M_FIN | M_SYN | M_RST)) | M_PSH;
          else if (pick < 14) fl = (fl & ~(M_FIN | M_PSH)) | M_ACK;
          else fl = fl | M_FIN;
        end
        default: fl = fl | M_ACK;
      endcase
    end
    send_item(op, fl, sq, ak, len, iss);
  endtask

  // Events the block must ignore (segment while closed, bad opcode, reopen) around a listen that opens it.
  task automatic test_ignored_events();
    send_item(OP_SEGMENT, 8'hFF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, M_SYN, 32'h1234_5678, 32'h0, 16'h0, 32'h0);
    send_item(OP_LISTEN, 8'h00, 32'h0, 32'hFFFF_FFFF, 16'h0, 32'h0);
    send_item(OP_LISTEN, 8'h00, 32'h0, 32'h0, 16'h0, 32'h0);
    send_item(OP_CONNECT, 8'hFF, 32'h0, 32'h0, 16'h0, 32'h0);
    send_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'h0);
  endtask

  // Passive open through data transfer to a peer-initiated close.
  task automatic test_passive_session();
    send_item(OP_SEGMENT, M_ACK, 32'h10, 32'h20, 16'h0, 32'h30);
    send_item(OP_SEGMENT, M_SYN, 32'hFFFF_FFFF, 32'h0, 16'h0, 32'hFFFF_FFFF);
    send_item(OP_SEGMENT, M_SYN | M_ACK, 32'h5, 32'h6, 16'h1, 32'h0);
    send_item(OP_SEGMENT, M_ACK | M_SPARE, 32'h1000, 32'h1, 16'hFFFF, 32'h0);
    send_item(OP_SEGMENT, M_PSH | M_SPARE, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
              16'hFFFF, 32'h0);
    send_item(OP_SEGMENT, M_ACK, 32'h55AA_55AA, 32'hAA55_AA55, 16'h10, 32'h0);
    send_item(OP_SEGMENT, M_PSH | M_RST | M_ACK, 32'h7777, 32'h8888, 16'h4,
              32'h0);
    send_item(OP_SEGMENT, 8'h00, 32'h1, 32'h2, 16'h3, 32'h4);
    send_item(OP_SEGMENT, M_FIN | M_PSH | M_ACK, 32'hFFFF_FFFF, 32'h9, 16'h2,
              32'h0);
    send_item(OP_SEGMENT, M_FIN, 32'h100, 32'h200, 16'h0, 32'h0);
    send_item(OP_SEGMENT, M_ACK, 32'h101, 32'h201, 16'h0, 32'h0);
  endtask

  // Active open: SYN-ACK from the peer, empty push, then FIN, leaving it in close-wait.
  task automatic test_active_session();
    send_item(OP_CONNECT, 8'h00, 32'h0, 32'h0, 16'h0, 32'h0);
    send_item(OP_SEGMENT, M_SYN, 32'h40, 32'h50, 16'h0, 32'h0);
    send_item(OP_LISTEN, 8'h00, 32'h0, 32'h0, 16'h0, 32'h0);
    send_item(OP_SEGMENT, M_SYN | M_ACK, 32'hFFFF_FFFF, 32'h0, 16'h0,
              32'hFFFF_FFFF);
    send_item(OP_SEGMENT, M_PSH | M_ACK, 32'h2000, 32'h3000, 16'h0, 32'h0);
    send_item(OP_SEGMENT, M_FIN | M_ACK, 32'h2000, 32'h3000, 16'h0, 32'h0);
  endtask

  task automatic test_random_sessions();
    repeat (RANDOM_ITEMS) send_random_item();
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Every result taken from the block is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    seg_result_t want;
    if (out_res.valid && out_res.ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual state %0d mark %h",
                 $time, out_res.next_state, out_res.received_mark);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        compare_field("send_segment", 32'(want.send_segment), 32'(out_res.send_segment));
        compare_field("reply_flags", 32'(want.reply_flags), 32'(out_res.reply_flags));
        compare_field("reply_seq", want.reply_seq, out_res.reply_seq);
        compare_field("reply_ack", want.reply_ack, out_res.reply_ack);
        compare_field("socket_notice", 32'(want.socket_notice),
                      32'(out_res.socket_notice));
        compare_field("deliver_payload", 32'(want.deliver_payload),
                      32'(out_res.deliver_payload));
        compare_field("release_connection", 32'(want.release_connection),
                      32'(out_res.release_connection));
        compare_field("next_state", 32'(want.next_state), 32'(out_res.next_state));
        compare_field("received_mark", want.received_mark, out_res.received_mark);
      end
    end
  end

  // Receiver back-pressure: rx_cycle periodically redraws the stall pattern at random.
  logic [31:0] rx_cycle = '0;
  logic [1:0]  rx_mode  = RX_OPEN;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 32'd1;
    if (rx_cycle % 97 == 0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:  out_res.ready <= 1'b1;
      RX_LIGHT: out_res.ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_res.ready <= ($urandom_range(0, 3) == 0);
      RX_COMB:  out_res.ready <= (rx_cycle[2:0] != 3'd5) && (rx_cycle[4:3] != 2'd2);
      default:  out_res.ready <= 1'b1;
    endcase
  end

  // Watchdog: ends the run if neither channel moves for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_seg.valid && in_seg.ready) || (out_res.valid && out_res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_seg.valid          <= 1'b0;
    in_seg.operation      <= OP_SEGMENT;
    in_seg.tcp_flags      <= '0;
    in_seg.seg_seq        <= '0;
    in_seg.seg_ack        <= '0;
    in_seg.payload_length <= '0;
    in_seg.initial_seq    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ignored_events();
    test_passive_session();
    test_active_session();
    test_random_sessions();
    in_seg.valid <= 1'b0;

    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
